// File: rtl/bpa_pkg.sv
package bpa_pkg;

   localparam int TOTAL_PAGES_DEF = 4096;

   localparam int COUNT_W  = 16;
   localparam int PAGE_W   = 12;
   localparam int STATUS_W = 2;
   localparam int NEED_W   = COUNT_W + 1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd2;

   // round a page count up to a power of two, zero counts as one
   function automatic logic [NEED_W-1:0] ceil_pow2(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] v;
      v = count - COUNT_W'(1);
      v = v | (v >> 1);
      v = v | (v >> 2);
      v = v | (v >> 4);
      v = v | (v >> 8);
      if (count == '0) begin
         return NEED_W'(1);
      end
      return {1'b0, v} + NEED_W'(1);
   endfunction

endpackage

// File: rtl/buddy_page_allocator.sv
// Allocate of 2^k pages: descent from the root to a free block of 2^k pages, then a climb back up.
// Free: climb from the leaf; an allocate larger than the tree or a free outside it skips the walk.
// One item at a time; the tree walk with one node read and one write per level
// sets the rate.
// Reset is synchronous; a clearing pass over all nodes of the tree
// loads every node with its subtree size before the first request transfer.
module buddy_page_allocator #(
   parameter int TOTAL_PAGES = bpa_pkg::TOTAL_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] page_count, [27:16] page_number
   input  logic        req_tuser,  // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [11:0] first_page
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   localparam int TREE_SIZE  = 2 ** $clog2(TOTAL_PAGES);
   localparam int LEVELS     = $clog2(TREE_SIZE);
   localparam int NODE_COUNT = 2 * TREE_SIZE - 1;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int VAL_W      = LEVELS + 1;
   localparam int NEED_W     = bpa_pkg::NEED_W;
   localparam int PAGE_W     = bpa_pkg::PAGE_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ROOT,
      S_DOWN,
      S_CLIMB,
      S_UP,
      S_RESP
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [VAL_W-1:0]             size_ff, size_in;
   logic [VAL_W-1:0]             need_ff, need_in;
   logic [VAL_W-1:0]             val_ff, val_in;
   logic [LEVELS-1:0]            page_ff, page_in;
   logic                         op_ff, op_in;
   logic [bpa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]            rsp_page_ff, rsp_page_in;
   logic [bpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [VAL_W-1:0] mem [NODE_COUNT];
   logic [VAL_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;

   logic [bpa_pkg::COUNT_W-1:0] req_count;
   logic [PAGE_W-1:0]           req_page;
   logic [NEED_W-1:0]           need_full;
   logic [IDX_W-1:0]            left_idx, next_idx, parent_idx, clr_next;
   logic [VAL_W-1:0]            half_size, dbl_size, sib_max, merge_val;
   logic [VAL_W:0]              pair_sum;
   logic                        go_left;
   logic [PAGE_W+LEVELS-1:0]    page_wide;

   function automatic logic [IDX_W-1:0] sibling(input logic [IDX_W-1:0] n);
      return n[0] ? n + IDX_W'(1) : n - IDX_W'(1);
   endfunction

   assign req_count = req_tdata[15:0];
   assign req_page  = req_tdata[27:16];
   assign need_full = bpa_pkg::ceil_pow2(req_count);

   assign left_idx   = {idx_ff[IDX_W-2:0], 1'b1};
   assign go_left    = rd_data_ff >= need_ff;
   assign next_idx   = go_left ? left_idx : left_idx + IDX_W'(1);
   assign half_size  = size_ff >> 1;
   assign dbl_size   = size_ff << 1;
   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign clr_next   = idx_ff + IDX_W'(1);
   assign sib_max    = (val_ff > rd_data_ff) ? val_ff : rd_data_ff;
   assign pair_sum   = {1'b0, val_ff} + {1'b0, rd_data_ff};
   assign merge_val  = (op_ff == bpa_pkg::OP_FREE && pair_sum == {1'b0, dbl_size})
                       ? dbl_size : sib_max;
   assign page_wide  = {{PAGE_W{1'b0}}, page_ff};

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      size_in       = size_ff;
      need_in       = need_ff;
      val_in        = val_ff;
      page_in       = page_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = val_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == IDX_W'(NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               idx_in = clr_next;
               if (((clr_next + IDX_W'(1)) & clr_next) == '0) begin
                  val_in = val_ff >> 1;
               end
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               page_in = '0;
               if (req_tuser == bpa_pkg::OP_ALLOC) begin
                  if (need_full > NEED_W'(TREE_SIZE)) begin
                     status_in = bpa_pkg::ST_NOSPACE;
                     state_in  = S_RESP;
                  end else begin
                     need_in  = VAL_W'(need_full);
                     idx_in   = '0;
                     rd_addr  = '0;
                     size_in  = VAL_W'(TREE_SIZE);
                     state_in = S_ROOT;
                  end
               end else begin
                  if ({5'b0, req_page} >= NEED_W'(TREE_SIZE)) begin
                     status_in = bpa_pkg::ST_NOTALLOC;
                     state_in  = S_RESP;
                  end else begin
                     idx_in   = IDX_W'({5'b0, req_page}) + IDX_W'(TREE_SIZE - 1);
                     rd_addr  = IDX_W'({5'b0, req_page}) + IDX_W'(TREE_SIZE - 1);
                     size_in  = VAL_W'(1);
                     state_in = S_CLIMB;
                  end
               end
            end
         end
         S_ROOT: begin
            if (rd_data_ff < need_ff) begin
               status_in = bpa_pkg::ST_NOSPACE;
               state_in  = S_RESP;
            end else if (size_ff == need_ff) begin
               wr_en     = 1'b1;
               wr_addr   = '0;
               wr_data   = '0;
               status_in = bpa_pkg::ST_OK;
               state_in  = S_RESP;
            end else begin
               rd_addr  = IDX_W'(1);
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            idx_in  = next_idx;
            size_in = half_size;
            if (!go_left) begin
               page_in = page_ff | LEVELS'(half_size);
            end
            if (half_size == need_ff) begin
               wr_en    = 1'b1;
               wr_addr  = next_idx;
               wr_data  = '0;
               val_in   = '0;
               rd_addr  = sibling(next_idx);
               state_in = S_UP;
            end else begin
               rd_addr = {next_idx[IDX_W-2:0], 1'b1};
            end
         end
         S_CLIMB: begin
            if (rd_data_ff != '0) begin
               if (idx_ff == '0) begin
                  status_in = bpa_pkg::ST_NOTALLOC;
                  state_in  = S_RESP;
               end else begin
                  idx_in  = parent_idx;
                  rd_addr = parent_idx;
                  size_in = dbl_size;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = size_ff;
               val_in  = size_ff;
               if (idx_ff == '0) begin
                  status_in = bpa_pkg::ST_OK;
                  state_in  = S_RESP;
               end else begin
                  rd_addr  = sibling(idx_ff);
                  state_in = S_UP;
               end
            end
         end
         S_UP: begin
            wr_en   = 1'b1;
            wr_addr = parent_idx;
            wr_data = merge_val;
            val_in  = merge_val;
            idx_in  = parent_idx;
            size_in = dbl_size;
            rd_addr = sibling(parent_idx);
            if (parent_idx == '0) begin
               status_in = bpa_pkg::ST_OK;
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_page_in   = (op_ff == bpa_pkg::OP_ALLOC && status_ff == bpa_pkg::ST_OK)
                               ? page_wide[PAGE_W-1:0] : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         val_ff       <= VAL_W'(TREE_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         val_ff       <= val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff       <= size_in;
      need_ff       <= need_in;
      page_ff       <= page_in;
      op_ff         <= op_in;
      status_ff     <= status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_page_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("illegal status code");

   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != bpa_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("failed item carries a nonzero page");

   a_descent_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DOWN |-> size_ff > need_ff)
      else $error("descent passed the requested block size");

   a_write_in_tree: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr <= IDX_W'(NODE_COUNT - 1))
      else $error("node write outside the tree");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request transfer taken during a walk");

endmodule
